/* src/lbp_3x3_pixel_coder_macros.svh */
// Assertion macros shared by the LBP coder RTL.
`ifndef LBP_3X3_PIXEL_CODER_MACROS_SVH
`define LBP_3X3_PIXEL_CODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lbp_pkg.sv */
// Package: types, register map and the pattern code function of the LBP coder.
`timescale 1ns / 1ps

package lbp_pkg;

  typedef logic [7:0] pixel_t;

  // Configuration register width and size arithmetic width (holds up to 8192).
  localparam int SIZE_W = 13;
  localparam int LIM_W  = 14;

  typedef logic [SIZE_W-1:0] size_reg_t;
  typedef logic [LIM_W-1:0]  size_lim_t;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_FRAME_WIDTH  = 3'h0;
  localparam logic [2:0] ADDR_FRAME_HEIGHT = 3'h4;

  localparam size_reg_t FRAME_WIDTH_RESET  = 13'd640;
  localparam size_reg_t FRAME_HEIGHT_RESET = 13'd480;
  localparam size_lim_t SIZE_MIN           = 14'd3;

  // Saturate a programmed size into [3, hi].
  function automatic size_lim_t clamp_size(input size_reg_t v, input size_lim_t hi);
    size_lim_t ext;
    ext = {1'b0, v};
    if (ext < SIZE_MIN) begin
      return SIZE_MIN;
    end else if (ext > hi) begin
      return hi;
    end
    return ext;
  endfunction

  // One bit per neighbor, set when it is strictly brighter than the center.
  function automatic pixel_t pattern_code(
    input pixel_t top_left,
    input pixel_t top,
    input pixel_t top_right,
    input pixel_t right,
    input pixel_t bottom_right,
    input pixel_t bottom,
    input pixel_t bottom_left,
    input pixel_t left,
    input pixel_t center
  );
    pixel_t code;
    code[7] = top_left     > center;
    code[6] = top          > center;
    code[5] = top_right    > center;
    code[4] = right        > center;
    code[3] = bottom_right > center;
    code[2] = bottom       > center;
    code[1] = bottom_left  > center;
    code[0] = left         > center;
    return code;
  endfunction

endpackage

/* src/lbp_3x3_pixel_coder.sv */
// Top level: streaming 3x3 local binary pattern coder with two line stores.
`timescale 1ns / 1ps
`include "lbp_3x3_pixel_coder_macros.svh"

// Streaming 3x3 LBP coder. Grey pixels enter in raster order, one request per
// clock, and the block sustains one pixel per clock unless a held result stalls
// the input. For every interior pixel it emits one result (pattern code, center
// column, center row) once the pixel below-right of that center has arrived;
// border pixels give no result. A result is offered once the pixel that
// completes it leaves stage 1: the accepting edge registers the pixel and its
// line store reads, the edge that advances stage 1 updates the window and loads
// the result register. A result held by the receiver stalls the input only when
// the next pixel also yields a result. Frame size comes from the frame_width and
// frame_height registers, saturated to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; the
// raster position wraps after the last pixel of a frame. Write them only while
// the pipeline is empty. Line stores start undefined and need a full row before
// they hold valid data, which raster order guarantees.
module lbp_3x3_pixel_coder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] pattern_code, [19:8] center_column,
                                 // [31:20] center_row
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam lbp_pkg::size_lim_t WIDTH_LIMIT  = lbp_pkg::size_lim_t'(MAX_WIDTH);
  localparam lbp_pkg::size_lim_t HEIGHT_LIMIT = lbp_pkg::size_lim_t'(MAX_HEIGHT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  lbp_pkg::size_reg_t frame_width;
  lbp_pkg::size_reg_t frame_height;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lbp_pkg::FRAME_WIDTH_RESET;
      frame_height <= lbp_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr)
        lbp_pkg::ADDR_FRAME_WIDTH:  frame_width  <= pwdata[lbp_pkg::SIZE_W-1:0];
        lbp_pkg::ADDR_FRAME_HEIGHT: frame_height <= pwdata[lbp_pkg::SIZE_W-1:0];
        default: ;  // drop writes outside the register map
      endcase
    end
  end

  always_comb begin
    case (paddr)
      lbp_pkg::ADDR_FRAME_WIDTH:  prdata = {{(32 - lbp_pkg::SIZE_W){1'b0}}, frame_width};
      lbp_pkg::ADDR_FRAME_HEIGHT: prdata = {{(32 - lbp_pkg::SIZE_W){1'b0}}, frame_height};
      default:                    prdata = '0;
    endcase
  end

  // Sizes in use, saturated into the supported range.
  lbp_pkg::size_lim_t width_lim;
  lbp_pkg::size_lim_t height_lim;

  assign width_lim  = lbp_pkg::clamp_size(frame_width, WIDTH_LIMIT);
  assign height_lim = lbp_pkg::clamp_size(frame_height, HEIGHT_LIMIT);

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s1_produce;
  logic s1_advance;
  logic accept;
  logic out_free;

  // The result register frees up when empty or drained this cycle. An item
  // that yields no result never waits on it.
  assign out_free   = !m_tvalid || m_tready;
  assign s1_advance = s1_valid && (out_free || !s1_produce);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Raster position of the next pixel
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]   column_position;
  logic [ROW_W-1:0]   row_position;
  logic [COL_W-1:0]   column_position_next;
  logic [ROW_W-1:0]   row_position_next;
  lbp_pkg::size_lim_t col_inc;
  lbp_pkg::size_lim_t row_inc;
  logic               col_wrap;
  logic               row_wrap;

  assign col_inc  = lbp_pkg::size_lim_t'(column_position) + lbp_pkg::size_lim_t'(1);
  assign row_inc  = lbp_pkg::size_lim_t'(row_position) + lbp_pkg::size_lim_t'(1);
  assign col_wrap = col_inc >= width_lim;
  assign row_wrap = row_inc >= height_lim;

  always_comb begin
    column_position_next = col_wrap ? '0 : col_inc[COL_W-1:0];
    row_position_next    = row_position;
    if (col_wrap) begin
      row_position_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accepted pixel, its position and the line store read data
  // ---------------------------------------------------------------------------
  lbp_pkg::pixel_t  s1_pixel;
  lbp_pkg::pixel_t  s1_top;
  lbp_pkg::pixel_t  s1_mid;
  logic [COL_W-1:0] s1_column;
  logic [ROW_W-1:0] s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= s_tdata;
      s1_column <= column_position;
      s1_row    <= row_position;
    end
  end

  // Line stores: read the column of the incoming pixel on accept, write it back
  // when the stage advances. Back-to-back pixels always touch different columns
  // (a row has at least three), so the write never collides with a pending read.
  lbp_pkg::pixel_t upper_line  [MAX_WIDTH];
  lbp_pkg::pixel_t middle_line [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_top <= upper_line[column_position];
      s1_mid <= middle_line[column_position];
    end
    if (s1_advance) begin
      upper_line[s1_column]  <= s1_mid;   // middle row moves up
      middle_line[s1_column] <= s1_pixel; // new pixel becomes middle row
    end
  end

  assign s1_produce = (s1_column >= COL_W'(2)) && (s1_row >= ROW_W'(2));

  // ---------------------------------------------------------------------------
  // 3x3 window, row-major, top row first; shifts left one column per pixel
  // ---------------------------------------------------------------------------
  lbp_pkg::pixel_t window [9];
  lbp_pkg::pixel_t code_next;

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= s1_top;
      window[3] <= window[4];
      window[4] <= window[5];
      window[5] <= s1_mid;
      window[6] <= window[7];
      window[7] <= window[8];
      window[8] <= s1_pixel;
    end
  end

  // Code from the window as it stands after this shift.
  assign code_next = lbp_pkg::pattern_code(
    window[1],  // top-left
    window[2],  // top
    s1_top,     // top-right
    s1_mid,     // right
    s1_pixel,   // bottom-right
    window[8],  // bottom
    window[7],  // bottom-left
    window[4],  // left
    window[5]   // center
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  lbp_pkg::pixel_t out_code;
  logic [11:0]     out_column;
  logic [11:0]     out_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance && s1_produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_produce) begin
      out_code   <= code_next;
      out_column <= 12'(s1_column - COL_W'(1));
      out_row    <= 12'(s1_row - ROW_W'(1));
    end
  end

  assign m_tdata = {out_row, out_column, out_code};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LBP_ASSERT_NOW(a_stall_needs_full_output, s1_valid && !s1_advance,
    m_tvalid && !m_tready, "stage 1 stalled while the result register was free")
  `LBP_ASSERT_NEXT(a_result_follows_produce, s1_advance && s1_produce,
    m_tvalid, "coded item did not reach the result register")
  `LBP_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid,
    "accepted pixel did not enter stage 1")
  `LBP_ASSERT_NOW(a_no_border_result, m_tvalid,
    (out_column != 12'd0) && (out_row != 12'd0), "result issued for a border pixel")

endmodule

/* test/tb.sv */
// Self-checking testbench for the 3x3 local binary pattern coder.
`timescale 1ns / 1ps

// Drive grey pixels through the coder in raster order and check every result
// against a cycle-free model of the window and line stores kept here.
// Each accepted pixel request advances the model. The model queues the code
// it expects, and a checking process compares each result request with the
// oldest queued code, field by field. Frame size is programmed over the
// register port only while the pipeline is empty. The run covers reset
// values, hand-built windows, a resize in the middle of a frame, saturated
// widths and heights, random small frames, a long output stall and a final
// stretch at full rate.
module tb;

  localparam int MAX_W         = 4096;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 8;     // idle time after the last expected result
  localparam int STALL_LIMIT   = 2000;  // quiet cycles before the run is abandoned
  localparam int HOLD_CYCLES   = 300;   // long output stall in the pressure test
  localparam int RANDOM_PIXELS = 260;

  typedef enum int {PX_UNIFORM, PX_NARROW, PX_EXTREME} pixel_mix_t;

  typedef struct packed {
    lbp_pkg::pixel_t code;
    logic [11:0]     column;
    logic [11:0]     row;
  } lbp_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] pixel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [7:0] pattern_code, [19:8] center_column,
                                // [31:20] center_row

  // Model state: the two previous rows, the 3x3 window and the raster position.
  bit [7:0]           row_above     [MAX_W];
  bit [7:0]           row_two_above [MAX_W];
  bit [7:0]           win [9];
  int unsigned        col_pos;
  int unsigned        row_pos;
  lbp_pkg::size_reg_t width_reg  = lbp_pkg::FRAME_WIDTH_RESET;
  lbp_pkg::size_reg_t height_reg = lbp_pkg::FRAME_HEIGHT_RESET;

  lbp_result_t pending_codes[$];
  int unsigned failures;
  int unsigned pixels_sent;
  int unsigned quiet_cycles;
  int unsigned hold_off_cycles;
  bit          idling = 1'b1;

  lbp_3x3_pixel_coder #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  // Count every failure, but print only the first few.
  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int unsigned sat_size(input int unsigned v, input int unsigned hi);
    if (v < 3) begin
      return 3;
    end
    return (v > hi) ? hi : v;
  endfunction

  // Advance the model by one accepted pixel and queue the code it completes.
  // A pixel at column c, row r finishes the window centered on (c-1, r-1).
  task automatic code_pixel(input lbp_pkg::pixel_t px);
    int unsigned cols;
    int unsigned rows;
    int unsigned idx;
    int          k;
    bit [7:0]    ctr;
    lbp_result_t res;
    cols = sat_size(width_reg, MAX_W);
    rows = sat_size(height_reg, MAX_H);
    idx  = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    for (k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = row_two_above[idx];
    win[5] = row_above[idx];
    win[8] = px;
    row_two_above[idx] = row_above[idx];
    row_above[idx]     = px;
    if (col_pos >= 2 && row_pos >= 2) begin
      ctr = win[4];
      // Clockwise from top-left (bit 7) to left (bit 0); strictly greater only.
      res.code   = {win[0] > ctr, win[1] > ctr, win[2] > ctr, win[5] > ctr,
                    win[8] > ctr, win[7] > ctr, win[6] > ctr, win[3] > ctr};
      res.column = 12'(col_pos - 1);
      res.row    = 12'(row_pos - 1);
      pending_codes.insert(pending_codes.size(), res);
    end
    // A position past a shrunken size still wraps here, not earlier.
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) begin
        row_pos = 0;
      end
    end
  endtask

  function automatic lbp_pkg::pixel_t pick_pixel(input pixel_mix_t mix);
    case (mix)
      PX_UNIFORM: return lbp_pkg::pixel_t'($urandom);
      // Tight band: neighbors often equal the center.
      PX_NARROW:  return lbp_pkg::pixel_t'($urandom_range(118, 121));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'h01;
          2:       return 8'hFE;
          default: return 8'hFF;
        endcase
      end
    endcase
  endfunction

  // Offer one pixel request, at times after a random gap, and hold it
  // until accepted. Valid stays high afterwards for a back-to-back request.
  task automatic send_pixel(input lbp_pkg::pixel_t px);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    code_pixel(px);
    pixels_sent++;
  endtask

  // Send pixels until the raster position is back at the frame origin.
  task automatic send_frame(input pixel_mix_t mix);
    do send_pixel(pick_pixel(mix)); while (col_pos != 0 || row_pos != 0);
  endtask

  // Drop valid, wait for every queued code, then let the pipeline drain.
  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      lbp_pkg::ADDR_FRAME_WIDTH:  width_reg  = data[lbp_pkg::SIZE_W-1:0];
      lbp_pkg::ADDR_FRAME_HEIGHT: height_reg = data[lbp_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, input lbp_pkg::size_reg_t want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(32-lbp_pkg::SIZE_W){1'b0}}, want}) begin
      note_failure($sformatf("register at %0h: expected %0h, got %0h",
                             addr, want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program both sizes with junk above the register width, then read back.
  task automatic set_frame(input lbp_pkg::size_reg_t w, input lbp_pkg::size_reg_t h);
    apb_write(lbp_pkg::ADDR_FRAME_WIDTH,  ($urandom & 32'hFFFF_E000) | 32'(w));
    apb_write(lbp_pkg::ADDR_FRAME_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'(h));
    apb_read(lbp_pkg::ADDR_FRAME_WIDTH,  width_reg);
    apb_read(lbp_pkg::ADDR_FRAME_HEIGHT, height_reg);
  endtask

  // One 3x3 frame with a single center and uniform corners and sides.
  task automatic send_ring(input lbp_pkg::pixel_t corner, input lbp_pkg::pixel_t side,
                           input lbp_pkg::pixel_t center);
    int k;
    for (k = 0; k < 9; k++) begin
      if (k == 4) begin
        send_pixel(center);
      end else if (k % 2 == 0) begin
        send_pixel(corner);
      end else begin
        send_pixel(side);
      end
    end
  endtask

  task automatic check_reset_registers();
    apb_read(lbp_pkg::ADDR_FRAME_WIDTH,  lbp_pkg::FRAME_WIDTH_RESET);
    apb_read(lbp_pkg::ADDR_FRAME_HEIGHT, lbp_pkg::FRAME_HEIGHT_RESET);
  endtask

  // Smallest frame: each one codes exactly its middle pixel.
  task automatic check_corner_codes();
    set_frame(13'd3, 13'd3);
    send_ring(8'hFF, 8'hFF, 8'h00);   // every neighbor brighter
    send_ring(8'hFF, 8'hFF, 8'hFF);   // all equal: no bit set
    send_ring(8'hFF, 8'h00, 8'h80);   // corners only
    send_ring(8'h00, 8'h01, 8'h00);   // sides only
    settle_pipeline();
  endtask

  // Shrink width and height while the position lies beyond both new sizes.
  task automatic check_mid_frame_resize();
    set_frame(13'd6, 13'd6);
    repeat (22) send_pixel(pick_pixel(PX_UNIFORM));   // stop at column 4, row 3
    settle_pipeline();
    set_frame(13'd4, 13'd3);
    send_frame(PX_UNIFORM);
    settle_pipeline();
  endtask

  // Oversized width saturates to the widest row: part of a row must not wrap,
  // then a narrow frame picks up far past its own width.
  task automatic check_widest_frame();
    set_frame(13'h1FFF, 13'd0);
    repeat (40) send_pixel(pick_pixel(PX_UNIFORM));
    settle_pipeline();
    set_frame(13'd4, 13'd3);
    send_frame(PX_UNIFORM);
    settle_pipeline();
  endtask

  // Oversized height saturates to the tallest frame: rows past three still code.
  task automatic check_tallest_frame();
    set_frame(13'd1, 13'h1FFF);
    repeat (30) send_pixel(pick_pixel(PX_UNIFORM));
    settle_pipeline();
    set_frame(13'd3, 13'd3);
    send_frame(PX_UNIFORM);
    settle_pipeline();
  endtask

  task automatic check_random_frames();
    int unsigned start;
    int          n;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      set_frame(13'($urandom_range(0, 16)), 13'($urandom_range(0, 8)));
      n = $urandom_range(1, 2);
      repeat (n) send_frame(pixel_mix_t'($urandom_range(0, 2)));
      settle_pipeline();
    end
  endtask

  // Stall the output long enough for the coder to fill and block its input.
  task automatic check_back_pressure();
    set_frame(13'd16, 13'd6);
    hold_off_cycles = HOLD_CYCLES;
    send_frame(PX_UNIFORM);
    settle_pipeline();
  endtask

  task automatic check_full_rate();
    idling = 1'b0;
    set_frame(13'd24, 13'd8);
    send_frame(PX_UNIFORM);
    settle_pipeline();
  endtask

  // Output side: random stalls, the long hold-off on request, else ready.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        m_tready <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result request with the oldest queued code.
  always @(posedge clk) begin : check_results
    lbp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_codes.size() == 0) begin
        note_failure($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = pending_codes.pop_front();
        if (m_tdata[7:0] !== want.code) begin
          note_failure($sformatf("code at (%0d,%0d): expected %h, got %h",
                                 want.column, want.row, want.code, m_tdata[7:0]));
        end
        if (m_tdata[19:8] !== want.column) begin
          note_failure($sformatf("center column: expected %0d, got %0d",
                                 want.column, m_tdata[19:8]));
        end
        if (m_tdata[31:20] !== want.row) begin
          note_failure($sformatf("center row: expected %0d, got %0d",
                                 want.row, m_tdata[31:20]));
        end
      end
    end
  end

  // Abandon the run after too many cycles without any accepted request.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reset_registers();
    check_corner_codes();
    check_mid_frame_resize();
    check_widest_frame();
    check_tallest_frame();
    check_random_frames();
    check_back_pressure();
    check_full_rate();
    failures += pending_codes.size();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
